[design/llss_pkg.sv]
package llss_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int RATE_SCALE = 100;
  localparam logic [4:0] LIVE_MAX = 5'd31;

  typedef enum logic [2:0] {
    ST_FREE   = 3'd0,
    ST_INIT   = 3'd1,
    ST_USE    = 3'd2,
    ST_ERROR  = 3'd3,
    ST_NOTICE = 3'd4,
    ST_END    = 3'd5
  } status_code_t;

  typedef enum logic [1:0] {
    OP_PICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_SET  = 2'd2,
    OP_NOP  = 2'd3
  } op_code_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_NO_SRV  = 2'd1,
    ERR_FULL    = 2'd2
  } err_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK_RD,
    S_PICK_DIV,
    S_PICK_CMP,
    S_PICK_UPD,
    S_MATCH_RD,
    S_MATCH_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_APPLY,
    S_CNT_RD,
    S_CNT_CHK,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_clr;   // reset scan index and scan flags
    logic scan_inc;   // advance scan index
    logic pick_eval;  // evaluate pick candidate at scan index
    logic div_start;  // launch rate division
    logic div_step;   // one restoring-division step
    logic pick_cmp;   // compare rate against best
    logic pick_upd;   // bump best slot's count
    logic match_eval; // evaluate match at scan index
    logic refresh;    // refresh matched slot
    logic free_eval;  // evaluate free slot at scan index
    logic claim;      // claim found free slot
    logic apply_set;  // apply status change (set op / promotion / claim)
    logic cnt_clr;    // clear live counter accumulator
    logic cnt_eval;   // accumulate one slot into live count
    logic cnt_commit; // store live count
    logic out_fire;   // drive result strobe
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;   // scan index at final slot
    logic cur_end;     // slot at scan index is end marker
    logic pick_zero;   // candidate is live with zero use
    logic pick_cand;   // candidate is live and not full
    logic div_done;    // division finished
    logic have;        // pick has a best slot
    logic best_init;   // best slot is in init
    logic match_hit;   // live match found
    logic match_stop;  // match search gave up or hit non-live match
    logic free_hit;    // free slot found at scan index
    logic change_ok;   // pending status change takes effect
  } sts_t;

endpackage

[design/llss_ctrl.sv]
module llss_ctrl
  import llss_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic [1:0] in_op,
  input  sts_t   sts,
  output ctl_t   ctl,
  output logic   busy
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          ctl.scan_clr = 1'b1;
          case (op_code_t'(in_op))
            OP_PICK: state_nxt = S_PICK_RD;
            OP_ADD:  state_nxt = S_MATCH_RD;
            OP_SET:  state_nxt = S_APPLY;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PICK_RD: begin
        if (sts.cur_end) begin
          state_nxt = S_PICK_UPD;
        end else if (sts.pick_zero) begin
          ctl.pick_eval = 1'b1;
          state_nxt = S_PICK_UPD;
        end else if (sts.pick_cand) begin
          ctl.div_start = 1'b1;
          state_nxt = S_PICK_DIV;
        end else if (sts.scan_last) begin
          state_nxt = S_PICK_UPD;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_PICK_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          ctl.div_step = 1'b0;
          state_nxt = S_PICK_CMP;
        end
      end
      S_PICK_CMP: begin
        ctl.pick_cmp = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_PICK_UPD;
        end else begin
          ctl.scan_inc = 1'b1;
          state_nxt = S_PICK_RD;
        end
      end
      S_PICK_UPD: begin
        ctl.pick_upd = 1'b1;
        if (sts.have && sts.best_init) begin
          state_nxt = S_APPLY;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MATCH_RD: begin
        ctl.match_eval = 1'b1;
        state_nxt = S_MATCH_CHK;
      end
      S_MATCH_CHK: begin
        if (sts.match_hit) begin
          ctl.refresh = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.match_stop || sts.scan_last) begin
          ctl.scan_clr = 1'b1;
          state_nxt = S_FREE_RD;
        end else begin
          ctl.scan_inc = 1'b1;
          state_nxt = S_MATCH_RD;
        end
      end
      S_FREE_RD: begin
        ctl.free_eval = 1'b1;
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (sts.free_hit) begin
          ctl.claim = 1'b1;
          state_nxt = S_APPLY;
        end else if (sts.cur_end || sts.scan_last) begin
          state_nxt = S_DONE;
        end else begin
          ctl.scan_inc = 1'b1;
          state_nxt = S_FREE_RD;
        end
      end
      S_APPLY: begin
        if (sts.change_ok) begin
          ctl.apply_set = 1'b1;
          ctl.cnt_clr = 1'b1;
          state_nxt = S_CNT_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CNT_RD: begin
        if (sts.cur_end) begin
          ctl.cnt_commit = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ctl.cnt_eval = 1'b1;
          state_nxt = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        if (sts.scan_last) begin
          ctl.cnt_commit = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ctl.scan_inc = 1'b1;
          state_nxt = S_CNT_RD;
        end
      end
      S_DONE: begin
        ctl.out_fire = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[design/llss_dpath.sv]
module llss_dpath
  import llss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_host_key,
  input  logic [15:0] in_port_number,
  input  logic [15:0] in_conn_limit,
  input  logic [3:0]  in_entry_index,
  input  logic [2:0]  in_new_status,
  output sts_t        sts,
  output logic        out_strobe,
  output logic        out_found,
  output logic [3:0]  out_chosen_index,
  output logic [1:0]  out_error_code,
  output logic [4:0]  out_live_count,
  output logic        out_disconnect_request
);

  // table (small, read at one scan index plus fixed-place updates)
  logic [2:0]  status_r [ENTRIES];
  logic [31:0] host_r   [ENTRIES];
  logic [15:0] port_r   [ENTRIES];
  logic [15:0] limit_r  [ENTRIES];
  logic [15:0] use_r    [ENTRIES];
  logic [4:0]  live_r;

  // captured item
  logic [1:0]  op_r;
  logic [31:0] host_in_r;
  logic [15:0] port_in_r, limit_in_r;
  logic [3:0]  idx_in_r;
  logic [2:0]  nstat_r;

  // scan state
  logic [IDX_W-1:0] scan_r;
  logic [IDX_W-1:0] best_r;
  logic             have_r;
  logic [6:0]       min_rate_r;
  logic [4:0]       match_cnt_r;
  logic             match_stop_r, match_hit_r, free_hit_r;
  logic [4:0]       cnt_r;
  logic             disc_r;

  // division: use*100 / limit, restoring, one bit per cycle
  logic [22:0] dividend_r;
  logic [15:0] rem_r;
  logic [4:0]  div_cnt_r;
  logic [6:0]  quot_r;
  logic [15:0] divisor_r;

  // slot at scan index
  logic [2:0]  cur_stat;
  logic [15:0] cur_use, cur_lim;
  logic        cur_live;
  assign cur_stat = status_r[scan_r];
  assign cur_use  = use_r[scan_r];
  assign cur_lim  = limit_r[scan_r];
  assign cur_live = (cur_stat == ST_INIT) || (cur_stat == ST_USE);

  // pending status change target
  logic [IDX_W-1:0] tgt_idx;
  logic [2:0]       tgt_stat;
  logic             tgt_valid;
  always_comb begin
    case (op_code_t'(op_r))
      OP_PICK: begin
        tgt_idx = best_r;
        tgt_stat = ST_USE;
        tgt_valid = 1'b1;
      end
      OP_ADD: begin
        tgt_idx = scan_r;
        tgt_stat = ST_INIT;
        tgt_valid = 1'b1;
      end
      default: begin
        tgt_idx = idx_in_r[IDX_W-1:0];
        tgt_stat = nstat_r;
        tgt_valid = ({28'd0, idx_in_r} < 32'(ENTRIES)) && (nstat_r <= ST_END);
      end
    endcase
  end

  logic [2:0] tgt_old;
  assign tgt_old = status_r[tgt_idx];

  // status
  logic [16:0] rem_sh;
  assign rem_sh = {rem_r, dividend_r[22]};

  assign sts.scan_last  = (scan_r == IDX_W'(ENTRIES - 1));
  assign sts.cur_end    = (cur_stat == ST_END);
  assign sts.pick_zero  = cur_live && (cur_lim > cur_use) && (cur_use == 16'd0);
  assign sts.pick_cand  = cur_live && (cur_lim > cur_use);
  assign sts.div_done   = (div_cnt_r == 5'd0);
  assign sts.have       = have_r;
  assign sts.best_init  = (status_r[best_r] == ST_INIT);
  assign sts.match_hit  = match_hit_r;
  assign sts.match_stop = match_stop_r;
  assign sts.free_hit   = free_hit_r;
  assign sts.change_ok  = tgt_valid && (tgt_old != tgt_stat)
                          && !(tgt_old == ST_ERROR && tgt_stat == ST_NOTICE);

  logic [4:0] cnt_inc;
  assign cnt_inc = (cur_live && cnt_r != LIVE_MAX) ? cnt_r + 5'd1 : cnt_r;

  // item capture, scan and division
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r <= in_op;
      host_in_r <= in_host_key;
      port_in_r <= in_port_number;
      limit_in_r <= in_conn_limit;
      idx_in_r <= in_entry_index;
      nstat_r <= in_new_status;
      have_r <= 1'b0;
      best_r <= '0;
      min_rate_r <= 7'(RATE_SCALE);
      match_cnt_r <= '0;
      disc_r <= 1'b0;
    end
    if (ctl.scan_clr) begin
      scan_r <= '0;
    end else if (ctl.scan_inc) begin
      scan_r <= scan_r + 1'b1;
    end
    if (ctl.pick_eval) begin
      have_r <= 1'b1;
      best_r <= scan_r;
    end
    if (ctl.div_start) begin
      dividend_r <= 23'(cur_use) * 23'd100;
      divisor_r <= cur_lim;
      rem_r <= '0;
      quot_r <= '0;
      div_cnt_r <= 5'd23;
    end else if (ctl.div_step) begin
      if (rem_sh >= {1'b0, divisor_r}) begin
        rem_r <= 16'(rem_sh - {1'b0, divisor_r});
        quot_r <= {quot_r[5:0], 1'b1};
      end else begin
        rem_r <= rem_sh[15:0];
        quot_r <= {quot_r[5:0], 1'b0};
      end
      dividend_r <= {dividend_r[21:0], 1'b0};
      div_cnt_r <= div_cnt_r - 5'd1;
    end
    if (ctl.pick_cmp && quot_r < min_rate_r) begin
      min_rate_r <= quot_r;
      best_r <= scan_r;
      have_r <= 1'b1;
    end
    // matched or claimed slot, kept past the recount
    if (ctl.refresh || ctl.claim) begin
      best_r <= scan_r;
    end
    // match search: one slot per pass
    if (ctl.load || ctl.scan_clr) begin
      match_hit_r <= 1'b0;
      match_stop_r <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (ctl.match_eval) begin
      if (port_r[scan_r] != 16'd0) begin
        if (host_r[scan_r] == host_in_r && port_r[scan_r] == port_in_r) begin
          match_hit_r <= cur_live;
          match_stop_r <= 1'b1;
        end else if (cur_live) begin
          match_cnt_r <= match_cnt_r + 5'd1;
          match_stop_r <= (match_cnt_r + 5'd1 > live_r);
        end
      end
    end else if (ctl.free_eval) begin
      free_hit_r <= !sts.cur_end && (cur_stat == ST_FREE || cur_stat == ST_ERROR);
    end
    if (ctl.apply_set) begin
      disc_r <= (tgt_stat == ST_NOTICE);
      scan_r <= '0;
    end
    if (ctl.cnt_clr) begin
      cnt_r <= '0;
    end else if (ctl.cnt_eval) begin
      cnt_r <= cnt_inc;
    end
  end

  // table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        status_r[i] <= ST_FREE;
        host_r[i] <= '0;
        port_r[i] <= '0;
        limit_r[i] <= '0;
        use_r[i] <= '0;
      end
      live_r <= '0;
    end else begin
      if (ctl.pick_upd && have_r) begin
        use_r[best_r] <= use_r[best_r] + 16'd1;
      end
      if (ctl.refresh) begin
        limit_r[scan_r] <= limit_in_r;
        use_r[scan_r] <= '0;
      end
      if (ctl.claim) begin
        host_r[scan_r] <= host_in_r;
        port_r[scan_r] <= port_in_r;
        limit_r[scan_r] <= limit_in_r;
        use_r[scan_r] <= '0;
      end
      if (ctl.apply_set) begin
        status_r[tgt_idx] <= tgt_stat;
      end
      if (ctl.cnt_commit) begin
        live_r <= ctl.cnt_eval ? cnt_inc : cnt_r;
      end
    end
  end

  // result register
  logic found_w;
  always_comb begin
    case (op_code_t'(op_r))
      OP_PICK: found_w = have_r;
      OP_ADD:  found_w = match_hit_r || free_hit_r;
      default: found_w = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ctl.out_fire;
    end
    if (ctl.out_fire) begin
      out_found <= found_w;
      out_chosen_index <= found_w ? 4'(best_r) : 4'd0;
      out_error_code <= (op_r == OP_PICK && !have_r) ? ERR_NO_SRV :
                        (op_r == OP_ADD && !found_w) ? ERR_FULL : ERR_OK;
      out_live_count <= live_r;
      out_disconnect_request <= (op_r == OP_SET) && disc_r;
    end
  end

endmodule

[design/least_load_server_selector.sv]
// Least-load server selector.
// Command channel: drive the in_* fields with start high while busy is low;
// the item is taken at that clock edge and busy rises on the next cycle.
// Ops: pick (least loaded live server), add/refresh, set status, no-op.
// Result channel: one result per item, shown for exactly one cycle with
// out_strobe high; the receiver must take it then, it cannot stall.
// Flow after the transfer edge: a no-op goes straight to the result. A set-status
// item checks the change and, when it takes effect, runs the live recount over
// the table. A pick skips each slot that is no candidate and runs each loaded
// candidate through the 23-step bit-serial divider plus read and compare, then
// bumps the best slot's use count, plus the recount when an init server is
// promoted. An add walks the table twice, plus the recount when it claims
// a slot. busy stays high until the strobe cycle, so items are handled one
// at a time.
// Reset (rst_n low, synchronous): all slots free with zero fields, live
// count zero, controller idle, no strobe.
module least_load_server_selector
  import llss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_host_key,
  input  logic [15:0] in_port_number,
  input  logic [15:0] in_conn_limit,
  input  logic [3:0]  in_entry_index,
  input  logic [2:0]  in_new_status,
  output logic        out_strobe,
  output logic        out_found,
  output logic [3:0]  out_chosen_index,
  output logic [1:0]  out_error_code,
  output logic [4:0]  out_live_count,
  output logic        out_disconnect_request
);

  ctl_t ctl;
  sts_t sts;

  llss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  llss_dpath u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctl                    (ctl),
    .in_op                  (in_op),
    .in_host_key            (in_host_key),
    .in_port_number         (in_port_number),
    .in_conn_limit          (in_conn_limit),
    .in_entry_index         (in_entry_index),
    .in_new_status          (in_new_status),
    .sts                    (sts),
    .out_strobe             (out_strobe),
    .out_found              (out_found),
    .out_chosen_index       (out_chosen_index),
    .out_error_code         (out_error_code),
    .out_live_count         (out_live_count),
    .out_disconnect_request (out_disconnect_request)
  );

  // a transfer in leads to busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // strobe only at end of work
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("strobe without work");

  // a found result never reports an error
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_found) |-> (out_error_code == ERR_OK))
    else $error("found with error code");

endmodule
